// ===== sv/ncib_pkg.sv =====
// shared types, constants and coefficient tables for the normal cdf / inverse unit
// no dependencies; used by every module of the block
package ncib_pkg;

    // width of z, bisection bounds and midpoints (holds +/-6.0 at up to 30 fraction bits)
    localparam int ZW = 34;
    // width of the q30 horner accumulator
    localparam int AW = 34;
    // width of the horner multiplier operand
    localparam int TW = 32;
    // horner steps after the leading coefficient
    localparam int NSTEP = 14;
    // register stages from z in to cdf out of one evaluation pipe
    localparam int CDF_LAT = 3 + 2 * NSTEP + 1;

    localparam logic signed [TW-1:0] ONE_T = 32'sh4000_0000;

    // decimal constant scaled by 1e-12, rounded to nearest q30
    function automatic longint cq(input longint n);
        longint m;
        m = (n < 0) ? -n : n;
        m = (m * 64'sd262144 + 64'sd122070312) / 64'sd244140625;
        return (n < 0) ? -m : m;
    endfunction

    localparam longint LOW_POLY [0:8] = '{
        cq(64'sd124818987), cq(-64'sd1075204047), cq(64'sd5198775019),
        cq(-64'sd19198292004), cq(64'sd59054035642), cq(-64'sd151968751364),
        cq(64'sd319152932694), cq(-64'sd531923007300), cq(64'sd797884560593)
    };

    localparam longint MID_POLY [0:14] = '{
        cq(-64'sd45255659), cq(64'sd152529290), cq(-64'sd19538132),
        cq(-64'sd676904986), cq(64'sd1390604284), cq(-64'sd794620820),
        cq(-64'sd2034254874), cq(64'sd6549791214), cq(-64'sd10557625006),
        cq(64'sd11630447319), cq(-64'sd9279453341), cq(64'sd5353579108),
        cq(-64'sd2141268741), cq(64'sd535310849), cq(64'sd999936657524)
    };

    function automatic longint low_coef(input int k);
        longint c;
        c = 0;
        if (k >= 0 && k <= 8) begin
            c = LOW_POLY[k];
        end
        return c;
    endfunction

    function automatic longint mid_coef(input int k);
        longint c;
        c = 0;
        if (k >= 0 && k <= 14) begin
            c = MID_POLY[k];
        end
        return c;
    endfunction

    // per-item sideband that rides along the horner cells
    typedef struct packed {
        logic                 low;   // |z|/2 below one: odd polynomial in y
        logic                 zero;  // z is exactly zero
        logic                 big;   // |z| at or above six
        logic                 pos;   // z above zero
        logic [TW-1:0]        w;     // y*y in q30
        logic [TW-1:0]        y;     // |z|/2 in q30
        logic signed [TW-1:0] tm;    // y - 2 in q30
    } t_cdf_side;

    // bisection state handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 kind;
        logic                 special;
        logic signed [31:0]   p;
        logic signed [ZW-1:0] lo;
        logic signed [ZW-1:0] hi;
        logic signed [ZW-1:0] mid;
        logic [31:0]          res;
    } t_bis_state;

endpackage

// ===== sv/normal_cdf_and_inverse_bisection_unit.sv =====
// top level of the normal cdf and inverse cdf unit
// depends on ncib_pkg, ncib_bisect_cell, ncib_cdf_pipe, ncib_horner_cell
//
// usage
//   slave channel: one transfer per item; tuser selects the operation
//   (0 = cdf of z, 1 = inverse cdf of p), tdata carries the operand,
//   signed fixed point with FRAC_BITS fraction bits
//   master channel: one transfer per item, in input order, tdata holds the
//   probability (kind 0) or the z value (kind 1) in the same format
//   throughput: one item per cycle while the chain advances, any mix of kinds
//   path: an input register, ITERATIONS bisection cells (each a cdf pipe plus
//   one update register) and an output register; cdf items ride the same chain
//   and take their answer from the first cell
//   stall: the whole chain advances only while the output register is empty
//   or being taken, so s_axis_tready follows m_axis_tready
//   reset: synchronous active low, clears all valid flags; payload is not reset
//   probabilities at or below 0, at or above 1, or exactly one half invert to 0
module normal_cdf_and_inverse_bisection_unit #(
    parameter int ITERATIONS = 24,
    parameter int FRAC_BITS  = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] operand
    input  logic [0:0]  i_s_axis_tuser,   // [0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] result
);
    localparam int ZW = ncib_pkg::ZW;
    localparam logic signed [ZW-1:0] ONE  = ZW'(1) << FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF = ONE / 2;
    localparam logic signed [ZW-1:0] SIX  = ONE * 6;

    logic                  w_en;
    logic signed [ZW-1:0]  w_p;
    ncib_pkg::t_bis_state  n_in;
    ncib_pkg::t_bis_state  r_in;
    ncib_pkg::t_bis_state  w_chain [0:ITERATIONS];
    ncib_pkg::t_bis_state  w_end;
    logic                  r_out_valid;
    logic [31:0]           r_out_data;
    logic [31:0]           n_out_data;

    // global advance: output register empty or its transfer completes
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // entry state: bracket [-6, 6]; cdf items put z in mid for the first cell
    always_comb begin
        w_p          = ZW'($signed(i_s_axis_tdata));
        n_in.valid   = i_s_axis_tvalid;
        n_in.kind    = i_s_axis_tuser[0];
        n_in.special = w_p[ZW-1] || (w_p == '0) || (w_p >= ONE) || (w_p == HALF);
        n_in.p       = $signed(i_s_axis_tdata);
        n_in.lo      = -SIX;
        n_in.hi      = SIX;
        n_in.mid     = i_s_axis_tuser[0] ? '0 : w_p;
        n_in.res     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in <= n_in;
        end
    end

    assign w_chain[0] = r_in;

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
        ncib_bisect_cell #(
            .FRAC_BITS (FRAC_BITS),
            .FIRST     (i == 0)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_state (w_chain[i]),
            .o_state (w_chain[i+1])
        );
    end

    assign w_end = w_chain[ITERATIONS];

    // inverse result is the last midpoint, cut to 32 bits
    always_comb begin
        if (!w_end.kind) begin
            n_out_data = w_end.res;
        end else if (w_end.special) begin
            n_out_data = '0;
        end else begin
            n_out_data = w_end.mid[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_end.valid;
            r_out_data  <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // a stalled chain holds the item at its end
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_end.valid))
        else $error("chain end moved during stall");

    // bisection never leaves the starting bracket
    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_end.valid && w_end.kind) |-> (w_end.mid >= -SIX && w_end.mid <= SIX))
        else $error("bisection midpoint out of range");

    // bracket stays ordered
    a_bracket_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_end.valid && w_end.kind) |-> (w_end.lo <= w_end.hi))
        else $error("bisection bracket inverted");
endmodule

// ===== sv/ncib_horner_cell.sv =====
// one horner step acc*t + c in q30, rounded on the magnitude, two register stages
// depends on ncib_pkg
module ncib_horner_cell #(
    parameter int K = 1
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [ncib_pkg::AW-1:0]   i_acc,
    input  ncib_pkg::t_cdf_side              i_side,
    output logic signed [ncib_pkg::AW-1:0]   o_acc,
    output ncib_pkg::t_cdf_side              o_side
);
    localparam int AW = ncib_pkg::AW;
    localparam int PW = ncib_pkg::AW + ncib_pkg::TW;
    localparam logic signed [AW-1:0] C_LOW = AW'(ncib_pkg::low_coef(K));
    localparam logic signed [AW-1:0] C_MID = AW'(ncib_pkg::mid_coef(K));

    logic signed [ncib_pkg::TW-1:0] n_t;
    logic signed [AW-1:0]           n_c;
    logic signed [PW-1:0]           r_prod;
    logic signed [AW-1:0]           r_c;
    ncib_pkg::t_cdf_side            r_side;
    logic                           w_neg;
    logic [PW-1:0]                  w_mag;
    logic [PW-1:0]                  w_rnd;
    logic [PW-1:0]                  w_q;
    logic signed [AW-1:0]           n_acc;
    logic signed [AW-1:0]           r_acc;
    ncib_pkg::t_cdf_side            r_side2;

    // low path: steps up to eight use w, step nine multiplies by y, the rest pass through
    always_comb begin
        if (i_side.low) begin
            if (K <= 8) begin
                n_t = $signed(i_side.w);
            end else if (K == 9) begin
                n_t = $signed(i_side.y);
            end else begin
                n_t = ncib_pkg::ONE_T;
            end
            n_c = C_LOW;
        end else begin
            n_t = i_side.tm;
            n_c = C_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(i_acc) * PW'(n_t);
            r_c    <= n_c;
            r_side <= i_side;
        end
    end

    always_comb begin
        w_neg = r_prod[PW-1];
        w_mag = w_neg ? PW'(-r_prod) : PW'(r_prod);
        w_rnd = (w_mag + (PW'(1) << 29)) >> 30;
        w_q   = w_neg ? (~w_rnd + PW'(1)) : w_rnd;
        n_acc = $signed(w_q[AW-1:0]) + r_c;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc   <= n_acc;
            r_side2 <= r_side;
        end
    end

    assign o_acc  = r_acc;
    assign o_side = r_side2;
endmodule

// ===== sv/ncib_cdf_pipe.sv =====
// pipelined standard normal cdf of a fixed-point z: prep, y*y, fourteen horner cells, final round
// depends on ncib_pkg and ncib_horner_cell
module ncib_cdf_pipe #(
    parameter int FRAC_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [ncib_pkg::ZW-1:0] i_z,
    output logic signed [ncib_pkg::ZW-1:0] o_cdf
);
    localparam int ZW = ncib_pkg::ZW;
    localparam int AW = ncib_pkg::AW;
    localparam int TW = ncib_pkg::TW;
    localparam int VW = AW + 2;
    localparam int SH = 31 - FRAC_BITS;
    localparam logic [ZW-1:0] SIX = ZW'(6) << FRAC_BITS;
    localparam logic signed [VW-1:0] ONE_V = VW'(1) << 30;

    logic [ZW-1:0]          w_mag;
    logic [63:0]            w_y64;
    logic [TW-1:0]          w_y;
    logic signed [TW:0]     w_tm;
    ncib_pkg::t_cdf_side    n_side0;
    ncib_pkg::t_cdf_side    r_side0;
    ncib_pkg::t_cdf_side    r_side1;
    logic [2*TW-1:0]        r_wprod;
    ncib_pkg::t_cdf_side    n_side2;
    ncib_pkg::t_cdf_side    r_side2;
    logic signed [AW-1:0]   r_acc0;
    logic [2*TW-1:0]        w_wr;

    logic signed [AW-1:0]   w_acc  [0:ncib_pkg::NSTEP];
    ncib_pkg::t_cdf_side    w_side [0:ncib_pkg::NSTEP];

    logic signed [VW-1:0]   w_x;
    logic signed [VW-1:0]   w_v;
    logic                   w_vneg;
    logic [VW-1:0]          w_vmag;
    logic [VW-1:0]          w_vr;
    logic [VW-1:0]          w_vq;
    logic signed [ZW-1:0]   r_cdf;

    always_comb begin
        w_mag  = i_z[ZW-1] ? ZW'(-i_z) : ZW'(i_z);
        w_y64  = (64'(w_mag) << (30 - FRAC_BITS)) >> 1;
        w_y    = w_y64[TW-1:0];
        // y - 2 in q30
        w_tm   = $signed({1'b0, w_y}) - $signed({1'b0, ncib_pkg::ONE_T})
                 - $signed({1'b0, ncib_pkg::ONE_T});
        n_side0.low  = (w_y < TW'(ncib_pkg::ONE_T));
        n_side0.zero = (i_z == '0);
        n_side0.big  = (w_mag >= SIX);
        n_side0.pos  = !i_z[ZW-1] && (i_z != '0);
        n_side0.w    = '0;
        n_side0.y    = w_y;
        n_side0.tm   = w_tm[TW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side0 <= n_side0;
            r_side1 <= r_side0;
            r_wprod <= (2*TW)'(r_side0.y) * (2*TW)'(r_side0.y);
            r_side2 <= n_side2;
            r_acc0  <= r_side1.low ? AW'(ncib_pkg::LOW_POLY[0]) : AW'(ncib_pkg::MID_POLY[0]);
        end
    end

    always_comb begin
        w_wr      = (r_wprod + ((2*TW)'(1) << 29)) >> 30;
        n_side2   = r_side1;
        n_side2.w = w_wr[TW-1:0];
    end

    assign w_acc[0]  = r_acc0;
    assign w_side[0] = r_side2;

    for (genvar k = 1; k <= ncib_pkg::NSTEP; k++) begin : g_cell
        ncib_horner_cell #(.K(k)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_acc  (w_acc[k-1]),
            .i_side (w_side[k-1]),
            .o_acc  (w_acc[k]),
            .o_side (w_side[k])
        );
    end

    always_comb begin
        if (w_side[ncib_pkg::NSTEP].zero) begin
            w_x = '0;
        end else if (w_side[ncib_pkg::NSTEP].big) begin
            w_x = ONE_V;
        end else if (w_side[ncib_pkg::NSTEP].low) begin
            w_x = VW'(w_acc[ncib_pkg::NSTEP]) <<< 1;
        end else begin
            w_x = VW'(w_acc[ncib_pkg::NSTEP]);
        end
        w_v    = w_side[ncib_pkg::NSTEP].pos ? (ONE_V + w_x) : (ONE_V - w_x);
        w_vneg = w_v[VW-1];
        w_vmag = w_vneg ? VW'(-w_v) : VW'(w_v);
        w_vr   = (w_vmag + (VW'(1) << (SH - 1))) >> SH;
        w_vq   = w_vneg ? (~w_vr + VW'(1)) : w_vr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cdf <= $signed(w_vq[ZW-1:0]);
        end
    end

    assign o_cdf = r_cdf;
endmodule

// ===== sv/ncib_bisect_cell.sv =====
// one bisection step: evaluates the cdf at the midpoint and narrows the bracket
// depends on ncib_pkg and ncib_cdf_pipe
module ncib_bisect_cell #(
    parameter int FRAC_BITS = 24,
    parameter bit FIRST     = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  ncib_pkg::t_bis_state  i_state,
    output ncib_pkg::t_bis_state  o_state
);
    localparam int ZW  = ncib_pkg::ZW;
    localparam int LAT = ncib_pkg::CDF_LAT;

    logic signed [ZW-1:0]  w_cdf;
    ncib_pkg::t_bis_state  r_dly [0:LAT-1];
    ncib_pkg::t_bis_state  w_last;
    ncib_pkg::t_bis_state  n_out;
    ncib_pkg::t_bis_state  r_out;
    logic                  w_gt;
    logic signed [ZW:0]    w_sum;

    ncib_cdf_pipe #(.FRAC_BITS(FRAC_BITS)) u_cdf (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_z   (i_state.mid),
        .o_cdf (w_cdf)
    );

    // state waits alongside the cdf evaluation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_dly[i].valid <= 1'b0;
            end
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_dly[0] <= i_state;
            for (int i = 1; i < LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
            r_out <= n_out;
        end
    end

    assign w_last = r_dly[LAT-1];

    always_comb begin
        n_out = w_last;
        w_gt  = w_cdf > ZW'(w_last.p);
        if (w_last.kind) begin
            if (w_gt) begin
                n_out.hi = w_last.mid;
            end else begin
                n_out.lo = w_last.mid;
            end
        end else if (FIRST) begin
            n_out.res = w_cdf[31:0];
        end
        w_sum     = (ZW+1)'(n_out.lo) + (ZW+1)'(n_out.hi);
        n_out.mid = w_last.kind ? w_sum[ZW:1] : w_last.mid;
    end

    assign o_state = r_out;
endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for normal_cdf_and_inverse_bisection_unit (cdf and inverse cdf)
// depends only on the unit and its package; predicts results in q30 fixed point where the table gives none
module tb_top;

    localparam int FRAC        = 24;
    localparam int STEPS       = 24;
    localparam int N_RANDOM    = 1300;
    localparam int IDLE_LIMIT  = 6000;
    localparam int DRAIN_WAIT  = 40;
    localparam longint ONE30   = 64'sd1 << 30;
    localparam longint ONE_OUT = 64'sd1 << FRAC;

    localparam bit KIND_CDF = 1'b0;
    localparam bit KIND_INV = 1'b1;

    // polynomial coefficients as decimal constants scaled by 1e12
    localparam longint LOW_DEC [0:8] = '{
        64'sd124818987, -64'sd1075204047, 64'sd5198775019, -64'sd19198292004,
        64'sd59054035642, -64'sd151968751364, 64'sd319152932694,
        -64'sd531923007300, 64'sd797884560593
    };
    localparam longint MID_DEC [0:14] = '{
        -64'sd45255659, 64'sd152529290, -64'sd19538132, -64'sd676904986,
        64'sd1390604284, -64'sd794620820, -64'sd2034254874, 64'sd6549791214,
        -64'sd10557625006, 64'sd11630447319, -64'sd9279453341, 64'sd5353579108,
        -64'sd2141268741, 64'sd535310849, 64'sd999936657524
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [31:0] operand
    logic [0:0]  i_s_axis_tuser;   // [0] kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [31:0] result

    normal_cdf_and_inverse_bisection_unit #(
        .ITERATIONS(STEPS),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // results still owed by the unit, oldest first
    logic [31:0] pending_results [$];
    int          error_count;
    int          idle_cycles;
    bit          no_idling;

    longint low_coef_q30 [0:8];
    longint mid_coef_q30 [0:14];

    // decimal/1e12 to q30, round to nearest on the magnitude
    function automatic longint dec_to_q30(input longint n);
        longint m;
        m = (n < 0) ? -n : n;
        m = (m * 64'sd262144 + 64'sd122070312) / 64'sd244140625;
        return (n < 0) ? -m : m;
    endfunction

    // shift right rounding to nearest, ties away from zero
    function automatic longint shift_round(input longint v, input int sh);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return shift_round(a * b, 30);
    endfunction

    // phi(z), z and result with FRAC fraction bits
    function automatic longint phi(input longint z);
        longint mag, x, y, w, acc;
        mag = (z < 0) ? -z : z;
        if (z == 0) begin
            x = 0;
        end else if (mag >= (64'sd6 << FRAC)) begin
            x = ONE30;
        end else begin
            y = (mag << (30 - FRAC)) >>> 1;
            if (y < ONE30) begin
                // odd polynomial: 2y * p(y*y)
                w = q30_mul(y, y);
                acc = low_coef_q30[0];
                for (int i = 1; i < 9; i++) acc = q30_mul(acc, w) + low_coef_q30[i];
                x = q30_mul(acc, y) * 2;
            end else begin
                acc = mid_coef_q30[0];
                for (int i = 1; i < 15; i++)
                    acc = q30_mul(acc, y - 2 * ONE30) + mid_coef_q30[i];
                x = acc;
            end
        end
        return shift_round((z > 0) ? ONE30 + x : ONE30 - x, 31 - FRAC);
    endfunction

    // inverse phi by bisection over [-6, 6], midpoint floored
    function automatic longint phi_inverse(input longint p);
        longint lo, hi, mid, s;
        lo = -6 * ONE_OUT;
        hi = 6 * ONE_OUT;
        mid = 0;
        if (p <= 0 || p >= ONE_OUT || p == ONE_OUT / 2) return 0;
        for (int i = 0; i < STEPS; i++) begin
            if (phi(mid) > p) hi = mid;
            else lo = mid;
            s = lo + hi;
            mid = (s >= 0) ? s / 2 : -((-s + 1) / 2);
        end
        return mid;
    endfunction

    function automatic logic [31:0] predict_result(input bit kind, input logic [31:0] operand);
        longint v;
        v = longint'($signed(operand));
        return (kind == KIND_INV) ? 32'(phi_inverse(v)) : 32'(phi(v));
    endfunction

    // directed stimulus; known marks rows whose answer is obvious
    typedef struct {
        bit          kind;
        logic [31:0] operand;
        bit          known;
        logic [31:0] result;
    } t_row;

    localparam int N_ROWS = 24;
    t_row rows [0:N_ROWS-1] = '{
        '{KIND_CDF, 32'h0000_0000, 1, 32'h0080_0000},   // zero z gives one half
        '{KIND_CDF, 32'h0600_0000, 1, 32'h0100_0000},   // z = 6 saturates to one
        '{KIND_CDF, 32'hFA00_0000, 1, 32'h0000_0000},   // z = -6 saturates to zero
        '{KIND_CDF, 32'h7FFF_FFFF, 1, 32'h0100_0000},   // largest z
        '{KIND_CDF, 32'h8000_0000, 1, 32'h0000_0000},   // most negative z
        '{KIND_CDF, 32'h05FF_FFFF, 0, 32'h0},           // just below six
        '{KIND_CDF, 32'hFA00_0001, 0, 32'h0},
        '{KIND_CDF, 32'h0000_0001, 0, 32'h0},           // smallest nonzero z
        '{KIND_CDF, 32'hFFFF_FFFF, 0, 32'h0},
        '{KIND_CDF, 32'h0100_0000, 0, 32'h0},
        '{KIND_CDF, 32'hFF00_0000, 0, 32'h0},
        '{KIND_CDF, 32'h0200_0000, 0, 32'h0},           // y = 1, start of middle segment
        '{KIND_CDF, 32'h01FF_FFFF, 0, 32'h0},           // end of low segment
        '{KIND_CDF, 32'hFE00_0000, 0, 32'h0},
        '{KIND_INV, 32'h0000_0000, 1, 32'h0000_0000},   // p = 0
        '{KIND_INV, 32'hFFFF_FFFF, 1, 32'h0000_0000},   // negative p
        '{KIND_INV, 32'h0100_0000, 1, 32'h0000_0000},   // p = 1
        '{KIND_INV, 32'h0080_0000, 1, 32'h0000_0000},   // p = one half
        '{KIND_INV, 32'h7FFF_FFFF, 1, 32'h0000_0000},
        '{KIND_INV, 32'h8000_0000, 1, 32'h0000_0000},
        '{KIND_INV, 32'h0000_0001, 0, 32'h0},           // tiny p, bottom of range
        '{KIND_INV, 32'h00FF_FFFF, 0, 32'h0},           // p just below one
        '{KIND_INV, 32'h0080_0001, 0, 32'h0},
        '{KIND_INV, 32'h00F9_999A, 0, 32'h0}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // output side: random backpressure, mostly short stalls
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (no_idling) begin
                i_m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < 80) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                          : $urandom_range(0, 3);
                i_m_axis_tready <= 1'b0;
            end
        end
    end

    // check every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata !== want) begin
                    $display("%0t: result mismatch, expected %h actual %h",
                             $time, want, o_m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, pending_results.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // present one item, hold it until the transfer, push its expected result
    task automatic send_item(input bit kind, input logic [31:0] operand,
                             input bit known, input logic [31:0] result);
        int gap;
        gap = 0;
        if (!no_idling && $urandom_range(0, 99) < 30)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= operand;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(known ? result : predict_result(kind, operand));
        @(negedge i_clk);
    endtask

    // random item: mostly in-range operands, some raw 32-bit noise
    task automatic send_random_item();
        bit          kind;
        logic [31:0] operand;
        int          pick;
        kind = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            operand = $urandom;
        end else if (kind == KIND_CDF) begin
            // z within about +/-7, hitting both polynomial segments and saturation
            operand = $urandom_range(0, 32'h0E00_0000) - 32'h0700_0000;
        end else if (pick < 25) begin
            // p close to the edges or to one half
            operand = ($urandom_range(0, 1) ? 32'h0000_0000 : 32'h0100_0000)
                      + $urandom_range(0, 64) - 32;
            if ($urandom_range(0, 1)) operand = 32'h0080_0000 + $urandom_range(0, 8) - 4;
        end else begin
            operand = $urandom_range(1, 32'h00FF_FFFF);
        end
        send_item(kind, operand, 1'b0, 32'h0);
    endtask

    initial begin
        for (int i = 0; i < 9; i++) low_coef_q30[i] = dec_to_q30(LOW_DEC[i]);
        for (int i = 0; i < 15; i++) mid_coef_q30[i] = dec_to_q30(MID_DEC[i]);
        error_count     = 0;
        idle_cycles     = 0;
        no_idling       = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int r = 0; r < N_ROWS; r++)
            send_item(rows[r].kind, rows[r].operand, rows[r].known, rows[r].result);

        // random part, with a stretch of full-rate traffic in the middle
        for (int n = 0; n < N_RANDOM; n++) begin
            no_idling = (n >= 500 && n < 800);
            send_random_item();
        end
        no_idling = 1'b0;
        i_s_axis_tvalid <= 1'b0;

        // drain; the watchdog bounds this wait
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ncib_pkg.sv
sv/ncib_horner_cell.sv
sv/ncib_cdf_pipe.sv
sv/ncib_bisect_cell.sv
sv/normal_cdf_and_inverse_bisection_unit.sv
test/tb_top.sv
